FILE: design/tmc_pkg.sv
`timescale 1ns / 1ps
package tmc_pkg;

  localparam int unsigned DefMaxLen = 4096;

  // Fixed field widths
  localparam int unsigned CursorW = 9;   // option cursor never passes 374
  localparam int unsigned OffW    = 12;

  localparam logic [15:0] FragOffMask  = 16'h1FFF;
  localparam logic [15:0] FragRsvMask  = 16'h80FF;
  localparam logic [16:0] ClampMargin  = 17'd50;
  localparam logic [7:0]  ProtoTcp     = 8'd6;
  localparam logic [3:0]  VersionIpv4  = 4'd4;
  localparam logic [7:0]  OptKindEnd   = 8'd0;
  localparam logic [7:0]  OptKindNop   = 8'd1;
  localparam logic [7:0]  OptKindMss   = 8'd2;
  localparam logic [7:0]  OptLenMss    = 8'd4;

  typedef enum logic [1:0] {
    OPT_WALKING = 2'd0,
    OPT_END     = 2'd1,
    OPT_MSS     = 2'd2,
    OPT_BAD     = 2'd3
  } opt_outcome_t;

  typedef enum logic [1:0] {
    PH_KIND    = 2'd0,
    PH_MSS_LEN = 2'd1,
    PH_OPT_LEN = 2'd2
  } opt_phase_t;

  typedef enum logic [1:0] {
    ST_UNCHANGED = 2'd0,
    ST_CLAMPED   = 2'd1,
    ST_MALFORMED = 2'd2
  } clamp_status_t;

  // Packet summary handed from the parser to the decision logic
  typedef struct packed {
    logic [3:0]   ihl;
    logic [3:0]   version;
    logic [7:0]   protocol;
    logic [15:0]  total_len;
    logic [15:0]  frag;
    logic [3:0]   doff;
    logic         syn;
    logic [31:0]  acc;
    logic [7:0]   hold;
    opt_outcome_t outcome;
    logic [OffW-1:0] mss_off;
    logic [15:0]  mss_val;
  } pkt_sum_t;

  typedef struct packed {
    logic [15:0]     new_checksum;
    logic [OffW-1:0] checksum_offset;
    logic [15:0]     new_mss;
    logic [OffW-1:0] mss_offset;
    clamp_status_t   status;
  } patch_t;

endpackage

FILE: design/tmc_decide.sv
`timescale 1ns / 1ps
module tmc_decide
  import tmc_pkg::*;
#(
  parameter int unsigned MAX_LEN = DefMaxLen,
  parameter int unsigned PW      = $clog2(MAX_LEN + 2)
) (
  input  logic [15:0]   limit_base,
  input  logic [PW-1:0] len,
  input  pkt_sum_t      sum,
  output patch_t        patch
);

  localparam logic [PW-1:0] MaxLenP = PW'(MAX_LEN);
  localparam logic [PW-1:0] MinLenP = PW'(20);

  logic [16:0] hdr, tl, tcp_len, limit, doff4;
  logic [16:0] len_x;
  logic [15:0] nm;
  logic [31:0] s;
  logic [16:0] f1;
  logic [16:0] f2;
  logic [15:0] ck;
  clamp_status_t st;

  always_comb begin
    hdr     = {11'd0, sum.ihl, 2'b00};
    tl      = {1'b0, sum.total_len};
    tcp_len = tl - hdr;
    doff4   = {11'd0, sum.doff, 2'b00};
    len_x   = 17'(len);
    limit   = {1'b0, limit_base} - ClampMargin;

    // Clamp: a negative limit is below every MSS
    nm = sum.mss_val;
    if (limit[16] || ({1'b0, sum.mss_val} > limit)) begin
      nm = limit[15:0];
    end

    // Checksum over accumulated words, patched MSS, length and protocol
    s = sum.acc;
    if (tcp_len[0]) begin
      s = s + {16'd0, sum.hold, 8'd0};
    end
    if (!sum.mss_off[0]) begin
      s = s + {16'd0, nm};
    end else begin
      s = s + {16'd0, nm[7:0], nm[15:8]};
    end
    s  = s + 32'd6 + {15'd0, tcp_len};
    f1 = {1'b0, s[15:0]} + {1'b0, s[31:16]};
    f2 = {1'b0, f1[15:0]} + {16'd0, f1[16]};
    ck = ~f2[15:0];

    // Decision chain, first match wins
    priority if (len > MaxLenP) begin
      st = ST_MALFORMED;
    end else if (limit_base == 16'd0) begin
      st = ST_UNCHANGED;
    end else if (len < MinLenP) begin
      st = ST_MALFORMED;
    end else if (sum.version != VersionIpv4 || sum.protocol != ProtoTcp) begin
      st = ST_UNCHANGED;
    end else if (len_x < hdr || len_x < tl || hdr > tl) begin
      st = ST_MALFORMED;
    end else if ((sum.frag & FragOffMask) != 16'd0 || (sum.frag & FragRsvMask) != 16'd0) begin
      st = ST_UNCHANGED;
    end else if (tcp_len < 17'd20) begin
      st = ST_MALFORMED;
    end else if (!sum.syn) begin
      st = ST_UNCHANGED;
    end else if (tcp_len < doff4) begin
      st = ST_MALFORMED;
    end else if (sum.outcome == OPT_BAD) begin
      st = ST_MALFORMED;
    end else if (sum.outcome != OPT_MSS) begin
      st = ST_UNCHANGED;
    end else begin
      st = ST_CLAMPED;
    end

    patch.status          = st;
    patch.checksum_offset = OffW'({sum.ihl, 2'b00}) + OffW'(16);
    patch.mss_offset      = (st == ST_CLAMPED) ? sum.mss_off : '0;
    patch.new_mss         = (st == ST_CLAMPED) ? nm : 16'd0;
    patch.new_checksum    = (st == ST_CLAMPED) ? ck : 16'd0;
  end

endmodule

FILE: design/tcp_mss_clamp.sv
`timescale 1ns / 1ps
// TCP MSS clamp for IPv4 packets streamed one byte per transfer.
// Slave side: s_tdata carries one packet byte, s_tlast marks the final byte.
// Master side: one patch transfer per packet, issued after the final byte;
// it gives the status (unchanged, clamped, malformed), where to write the
// new MSS and checksum, and their values. The packet itself is not modified.
// cfg_wr_en/cfg_wr_data write the path size base; zero disables clamping
// and the MSS is clamped to the base minus 50. Write it only while idle.
// Throughput: one byte per cycle while s_tready is high. Header fields, the
// option walk and the checksum sum advance on each accepted byte in a single
// register stage. Accepting the final byte loads the packet summary register,
// and the summary moves on to the patch register unless the receiver stalls;
// m_tvalid is set when the patch register is loaded.
// Reset clears all packet state and the base register, and drops any
// pending patch. When the receiver stalls, one further packet can finish
// into the summary register; s_tready falls only when both are full.
module tcp_mss_clamp
  import tmc_pkg::*;
#(
  parameter int unsigned MAX_LEN = DefMaxLen
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] pkt_byte
  input  logic        s_tlast,   // pkt_last
  output logic        m_tvalid,
  input  logic        m_tready,
  // [1:0] clamp_status, [13:2] mss_offset, [29:14] new_mss,
  // [41:30] checksum_offset, [57:42] new_checksum, [63:58] zero
  output logic [63:0] m_tdata
);

  localparam int unsigned PW = $clog2(MAX_LEN + 2);
  localparam int unsigned XW = (PW > 10) ? PW : 10;
  localparam logic [PW-1:0] MaxLenP = PW'(MAX_LEN);

  logic [15:0] limit_base;

  // Parse state
  logic [PW-1:0]      pos, pos_next;
  pkt_sum_t           st, st_next;
  logic [CursorW-1:0] cursor, cursor_next;
  opt_phase_t         phase, phase_next;

  logic [PW-1:0] len_snap;
  pkt_sum_t      sum_snap;
  logic          snap_valid;
  patch_t        patch, patch_q;
  logic          stall;
  logic          accept;

  assign stall    = m_tvalid && !m_tready;
  assign s_tready = !snap_valid || !stall;
  assign accept   = s_tvalid && s_tready;

  // Per-byte parsing and checksum
  logic [XW-1:0] p, hdr, opt_end, c, off;
  logic [7:0]    b, v;
  logic          take;

  always_comb begin
    st_next     = st;
    cursor_next = cursor;
    phase_next  = phase;
    pos_next    = pos;
    b           = s_tdata;
    v           = s_tdata;
    p           = XW'(pos);
    take        = pos < MaxLenP;
    hdr         = '0;
    opt_end     = '0;
    c           = '0;
    off         = '0;

    if (take) begin
      unique case (pos)
        PW'(0): begin
          st_next.ihl     = b[3:0];
          st_next.version = b[7:4];
        end
        PW'(2): st_next.total_len[15:8] = b;
        PW'(3): st_next.total_len[7:0]  = b;
        PW'(6): st_next.frag[15:8]      = b;
        PW'(7): st_next.frag[7:0]       = b;
        PW'(9): st_next.protocol        = b;
        default: ;
      endcase
      if (p >= XW'(12) && p <= XW'(19)) begin
        st_next.acc = st_next.acc + (p[0] ? {24'd0, b} : {16'd0, b, 8'd0});
      end
      hdr = XW'({st_next.ihl, 2'b00});
      if (pos == PW'(0)) begin
        cursor_next = CursorW'(hdr + XW'(20));
        phase_next  = PH_KIND;
      end
      if (p >= hdr) begin
        off = p - hdr;
        if (off == XW'(12)) st_next.doff = b[7:4];
        if (off == XW'(13)) st_next.syn  = b[1];

        // Option walk
        opt_end = hdr + XW'({st_next.doff, 2'b00});
        c       = XW'(cursor_next);
        if (st.outcome == OPT_WALKING) begin
          if (phase_next == PH_KIND) begin
            if (p == c && c < opt_end) begin
              priority if (b == OptKindEnd) begin
                st_next.outcome = OPT_END;
              end else if (b == OptKindNop) begin
                cursor_next = cursor_next + CursorW'(1);
              end else if (c + XW'(1) >= opt_end) begin
                st_next.outcome = OPT_BAD;
              end else begin
                phase_next = (b == OptKindMss) ? PH_MSS_LEN : PH_OPT_LEN;
              end
            end
          end else if (p == c + XW'(1)) begin
            if (phase_next == PH_MSS_LEN) begin
              if (b != OptLenMss || c + XW'(3) >= opt_end) begin
                st_next.outcome = OPT_BAD;
              end else begin
                st_next.outcome = OPT_MSS;
                st_next.mss_off = OffW'(c + XW'(2));
              end
            end else if (b <= 8'd1) begin
              st_next.outcome = OPT_BAD;
            end else begin
              cursor_next = cursor_next + CursorW'(b);
              phase_next  = PH_KIND;
            end
          end
        end

        // Segment sum; checksum and MSS bytes count as zero
        if (off < XW'(20) || 17'(p) < {1'b0, st_next.total_len}) begin
          if (off == XW'(16) || off == XW'(17)) v = 8'd0;
          if (st.outcome == OPT_MSS) begin
            if (p == XW'(st.mss_off)) begin
              st_next.mss_val[15:8] = b;
              v = 8'd0;
            end else if (p == XW'(st.mss_off) + XW'(1)) begin
              st_next.mss_val[7:0] = b;
              v = 8'd0;
            end
          end
          if (!off[0]) begin
            st_next.hold = v;
          end else begin
            st_next.acc = st_next.acc + {16'd0, st.hold, v};
          end
        end
      end
    end
    if (pos <= MaxLenP) pos_next = pos + PW'(1);
  end

  // Advance parse state; clear it after the final byte
  always_ff @(posedge clk) begin
    if (rst || (accept && s_tlast)) begin
      pos    <= '0;
      st     <= '0;
      cursor <= '0;
      phase  <= PH_KIND;
    end else if (accept) begin
      pos    <= pos_next;
      st     <= st_next;
      cursor <= cursor_next;
      phase  <= phase_next;
    end
  end

  // Hold the base register
  always_ff @(posedge clk) begin
    if (rst) begin
      limit_base <= 16'd0;
    end else if (cfg_wr_en) begin
      limit_base <= cfg_wr_data;
    end
  end

  // Capture the packet summary on the final byte
  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (s_tready) begin
      snap_valid <= accept && s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && accept && s_tlast) begin
      len_snap <= pos_next;
      sum_snap <= st_next;
    end
  end

  tmc_decide #(
    .MAX_LEN (MAX_LEN),
    .PW      (PW)
  ) u_decide (
    .limit_base (limit_base),
    .len        (len_snap),
    .sum        (sum_snap),
    .patch      (patch)
  );

  // Patch register; advance unless the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!stall) begin
      m_tvalid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall && snap_valid) begin
      patch_q <= patch;
    end
  end

  assign m_tdata = {6'd0, patch_q};

  // Checks
  a_ready_only_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (snap_valid && m_tvalid))
    else $error("input stalled while pipeline has room");

  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[1:0] != 2'd3))
    else $error("illegal patch status");

  a_unpatched_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1:0] != 2'd1) |-> (m_tdata[57:42] == 16'd0 && m_tdata[29:14] == 16'd0))
    else $error("patch values set without clamping");

  a_snap_to_out: assert property (@(posedge clk) disable iff (rst)
    (snap_valid && !stall) |=> m_tvalid)
    else $error("packet summary lost");

endmodule

FILE: tb/tcp_mss_clamp_checker.sv
`timescale 1ns / 1ps
module tcp_mss_clamp_checker
  import tmc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [63:0] m_tdata,
  output int          errors,
  output int          patches_due,
  output int          patches_seen,
  output int          clamps_seen
);

  localparam int unsigned MaxLen = DefMaxLen;

  // Shadow copy of the path size register and the per-packet parse state
  logic [15:0]  mss_base;
  int unsigned  pos, ihl, ver, proto, tot_len, frag, doff, syn;
  int unsigned  acc, hold, cur, mss_off, mss_val;
  opt_phase_t   phase;
  opt_outcome_t outcome;

  patch_t expected_patches[$];

  assign patches_due = expected_patches.size();

  function automatic void clear_packet();
    pos = 0; ihl = 0; ver = 0; proto = 0; tot_len = 0; frag = 0;
    doff = 0; syn = 0; acc = 0; hold = 0; cur = 0;
    mss_off = 0; mss_val = 0;
    phase = PH_KIND;
    outcome = OPT_WALKING;
  endfunction

  // Advance the TCP option walk by one byte
  function automatic void walk_options(int unsigned p, int unsigned b, int unsigned hdr);
    int unsigned opt_end;
    opt_end = hdr + doff * 4;
    if (outcome != OPT_WALKING) return;
    if (phase == PH_KIND) begin
      if (p != cur || cur >= opt_end) return;
      if (b == OptKindEnd) outcome = OPT_END;
      else if (b == OptKindNop) cur = cur + 1;
      else if (cur + 1 >= opt_end) outcome = OPT_BAD;
      else phase = (b == OptKindMss) ? PH_MSS_LEN : PH_OPT_LEN;
    end else if (p == cur + 1) begin
      if (phase == PH_MSS_LEN) begin
        if (b != OptLenMss || cur + 3 >= opt_end) outcome = OPT_BAD;
        else begin
          outcome = OPT_MSS;
          mss_off = cur + 2;
        end
      end else if (b <= 1) begin
        outcome = OPT_BAD;
      end else begin
        cur = cur + b;
        phase = PH_KIND;
      end
    end
  endfunction

  // Capture header fields and add the byte into the checksum sum
  function automatic void parse_byte(int unsigned p, int unsigned b);
    int unsigned hdr, off, v;
    if (p == 0) begin
      ihl = b & 15; ver = b >> 4;
    end else if (p == 2) tot_len = (tot_len & 'hFF) | (b << 8);
    else if (p == 3) tot_len = (tot_len & 'hFF00) | b;
    else if (p == 6) frag = (frag & 'hFF) | (b << 8);
    else if (p == 7) frag = (frag & 'hFF00) | b;
    else if (p == 9) proto = b;
    if (p >= 12 && p <= 19) acc += (p & 1) ? b : (b << 8);
    hdr = ihl * 4;
    if (p == 0) begin
      cur = hdr + 20;
      phase = PH_KIND;
    end
    if (p >= hdr) begin
      off = p - hdr;
      v = b;
      if (off == 12) doff = b >> 4;
      if (off == 13) syn = (b >> 1) & 1;
      walk_options(p, b, hdr);
      if (off < 20 || p < tot_len) begin
        if (off == 16 || off == 17) v = 0;
        if (outcome == OPT_MSS) begin
          if (p == mss_off) begin
            mss_val = (mss_val & 'hFF) | (b << 8); v = 0;
          end else if (p == mss_off + 1) begin
            mss_val = (mss_val & 'hFF00) | b; v = 0;
          end
        end
        if ((off & 1) == 0) hold = v;
        else acc += (hold << 8) | v;
      end
    end
  endfunction

  // Work out the patch for the packet that has just ended
  function automatic patch_t predict_patch();
    patch_t pt;
    int unsigned hdr, tcp_len, s, nm, rel;
    int          lim;
    pt = '0;
    hdr = ihl * 4;
    pt.checksum_offset = OffW'(hdr + 16);
    pt.status = ST_UNCHANGED;
    if (pos > MaxLen) pt.status = ST_MALFORMED;
    else if (mss_base == 0) pt.status = ST_UNCHANGED;
    else if (pos < 20) pt.status = ST_MALFORMED;
    else if (ver != VersionIpv4 || proto != ProtoTcp) pt.status = ST_UNCHANGED;
    else if (pos < hdr || pos < tot_len || hdr > tot_len) pt.status = ST_MALFORMED;
    else if ((frag & FragOffMask) != 0 || (frag & FragRsvMask) != 0)
      pt.status = ST_UNCHANGED;
    else begin
      tcp_len = tot_len - hdr;
      if (tcp_len < 20) pt.status = ST_MALFORMED;
      else if (syn == 0) pt.status = ST_UNCHANGED;
      else if (tcp_len < doff * 4) pt.status = ST_MALFORMED;
      else if (outcome == OPT_BAD) pt.status = ST_MALFORMED;
      else if (outcome == OPT_MSS) begin
        lim = int'(mss_base) - 50;
        nm = mss_val;
        if (int'(nm) > lim) nm = lim & 'hFFFF;
        s = acc;
        if (tcp_len & 1) s += hold << 8;
        rel = mss_off - hdr;
        if ((rel & 1) == 0) s += nm;
        else s += (nm >> 8) + ((nm & 'hFF) << 8);
        s += 6 + tcp_len;
        while (s >> 16) s = (s & 'hFFFF) + (s >> 16);
        pt.status = ST_CLAMPED;
        pt.new_mss = nm[15:0];
        pt.new_checksum = ~s[15:0];
        pt.mss_offset = OffW'(mss_off);
      end
    end
    return pt;
  endfunction

  // Track config writes, byte transfers and patch transfers
  always @(posedge clk) begin
    patch_t got, want;
    if (rst) begin
      mss_base <= '0;
      clear_packet();
      errors <= 0;
      patches_seen <= 0;
      clamps_seen <= 0;
    end else begin
      if (cfg_wr_en) mss_base <= cfg_wr_data;
      if (m_tvalid && m_tready) begin
        got = m_tdata[$bits(patch_t)-1:0];
        patches_seen <= patches_seen + 1;
        if (expected_patches.size() == 0) begin
          if (errors < 10) $display("[%0t] unexpected patch %h", $realtime, m_tdata);
          errors <= errors + 1;
        end else begin
          want = expected_patches.pop_front();
          if (want.status == ST_CLAMPED) clamps_seen <= clamps_seen + 1;
          if (got !== want || m_tdata[63:$bits(patch_t)] !== '0) begin
            if (errors < 10)
              $display("[%0t] patch mismatch: exp st=%0d moff=%0d mss=%h cko=%0d ck=%h",
                       $realtime, want.status, want.mss_offset, want.new_mss,
                       want.checksum_offset, want.new_checksum,
                       "  got st=%0d moff=%0d mss=%h cko=%0d ck=%h pad=%h",
                       got.status, got.mss_offset, got.new_mss,
                       got.checksum_offset, got.new_checksum,
                       m_tdata[63:$bits(patch_t)]);
            errors <= errors + 1;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        if (pos < MaxLen) parse_byte(pos, s_tdata);
        if (pos <= MaxLen) pos++;
        if (s_tlast) begin
          expected_patches.push_back(predict_patch());
          clear_packet();
        end
      end
    end
  end

endmodule

FILE: tb/tcp_mss_clamp_tb.sv
`timescale 1ns / 1ps
module tcp_mss_clamp_tb
  import tmc_pkg::*;
();

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_wr_en = 0;
  logic [15:0] cfg_wr_data = '0;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tlast = 0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [63:0] m_tdata;

  int errors, patches_due, patches_seen, clamps_seen;
  int bytes_sent, packets_sent;
  bit quiet;

  // Packet shape knobs
  int          p_ihl, p_ver, p_proto, p_frag, p_syn, p_doff, p_pay;
  int          p_tl_delta, p_tail, p_opt, p_cut;
  int unsigned p_mss;
  logic [7:0]  pkt_bytes[];

  always #1 clk = ~clk;

  tcp_mss_clamp uut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  tcp_mss_clamp_checker chk (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .errors(errors), .patches_due(patches_due), .patches_seen(patches_seen),
    .clamps_seen(clamps_seen)
  );

  // Receiver stalls in bursts
  always @(negedge clk) begin
    if (rst || quiet) m_tready <= 1;
    else if (!m_tready) m_tready <= ($urandom_range(0, 3) == 0);
    else m_tready <= ($urandom_range(0, 7) != 0);
  end

  task automatic clean_shape();
    p_ihl = 5; p_ver = 4; p_proto = 6; p_frag = 'h4000; p_syn = 1;
    p_doff = 6; p_pay = $urandom_range(0, 6); p_tl_delta = 0; p_tail = 0;
    p_opt = 0; p_cut = 0; p_mss = $urandom_range(0, 65535);
  endtask

  // Lay out one packet from the shape knobs
  task automatic assemble();
    int hdr, opt_len, tl, len;
    logic [7:0] opts[$];
    hdr = p_ihl * 4;
    opt_len = p_doff * 4 - 20;
    tl = hdr + p_doff * 4 + p_pay;
    len = tl + p_tail;
    if (len < 20) len = 20;
    if (p_cut > 0) len = p_cut;
    case (p_opt)
      0: begin
        repeat ($urandom_range(0, 2)) opts.push_back(OptKindNop);
        if ($urandom_range(0, 2) == 0) begin
          opts.push_back(8'd8); opts.push_back(8'd3); opts.push_back(8'($urandom));
        end
        opts.push_back(OptKindMss); opts.push_back(OptLenMss);
        opts.push_back(p_mss[15:8]); opts.push_back(p_mss[7:0]);
      end
      1: begin
        opts.push_back(OptKindNop); opts.push_back(OptKindEnd);
        opts.push_back(OptKindMss); opts.push_back(OptLenMss);
      end
      2: begin
        opts.push_back(8'd4); opts.push_back(8'd2);
      end
      3: begin
        opts.push_back(OptKindMss); opts.push_back(8'($urandom_range(0, 8)));
        opts.push_back(8'h05); opts.push_back(8'hB4);
      end
      4: begin
        opts.push_back(8'd5); opts.push_back(8'($urandom_range(0, 1)));
      end
      5: begin
        repeat (opt_len - 1) opts.push_back(OptKindNop);
        opts.push_back($urandom_range(0, 1) ? OptKindMss : 8'd3);
      end
      default: repeat (opt_len) opts.push_back(8'($urandom));
    endcase
    pkt_bytes = new[len];
    foreach (pkt_bytes[i]) pkt_bytes[i] = 8'($urandom);
    // TCP header first so the IP fields win where an undersized header overlaps
    for (int i = 0; i < opt_len; i++)
      if (hdr + 20 + i < len) pkt_bytes[hdr + 20 + i] = (i < opts.size()) ? opts[i] : OptKindNop;
    if (hdr + 12 < len) pkt_bytes[hdr + 12] = {p_doff[3:0], pkt_bytes[hdr + 12][3:0]};
    if (hdr + 13 < len) pkt_bytes[hdr + 13][1] = p_syn[0];
    pkt_bytes[0] = {p_ver[3:0], p_ihl[3:0]};
    tl = tl + p_tl_delta;
    if (len > 3) {pkt_bytes[2], pkt_bytes[3]} = tl[15:0];
    if (len > 7) {pkt_bytes[6], pkt_bytes[7]} = p_frag[15:0];
    if (len > 9) pkt_bytes[9] = p_proto[7:0];
  endtask

  // Push one byte, with occasional gaps before it
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      s_tvalid = 0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    s_tvalid = 1;
    s_tdata = b;
    s_tlast = last;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_packet();
    assemble();
    foreach (pkt_bytes[i]) send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
    packets_sent++;
  endtask

  // Write the register once the block has drained
  task automatic set_limit(input logic [15:0] v);
    s_tvalid = 0;
    while (patches_due != 0) @(negedge clk);
    repeat (5) @(negedge clk);
    cfg_wr_en = 1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en = 0;
  endtask

  task automatic random_shape();
    int pick;
    clean_shape();
    pick = $urandom_range(0, 99);
    p_doff = $urandom_range(5, 9);
    if (p_doff == 5) p_doff = 6;
    if (pick < 60) begin
      if ($urandom_range(0, 3) == 0) p_mss = $urandom_range(0, 2000);
      if ($urandom_range(0, 4) == 0) p_frag = 0;
    end else if (pick < 85) begin
      p_opt = $urandom_range(1, 6);
      if ($urandom_range(0, 3) == 0) p_doff = $urandom_range(5, 15);
    end else begin
      case ($urandom_range(0, 9))
        0: p_ihl = $urandom_range(0, 15);
        1: p_ver = $urandom_range(0, 15);
        2: p_proto = $urandom_range(0, 255);
        3: p_frag = $urandom_range(0, 65535);
        4: p_syn = 0;
        5: p_tl_delta = int'($urandom_range(0, 20)) - 10;
        6: p_tail = $urandom_range(1, 6);
        7: p_cut = $urandom_range(1, 40);
        8: p_pay = $urandom_range(0, 1);
        default: p_doff = $urandom_range(0, 15);
      endcase
    end
  endtask

  initial begin
    logic [15:0] limits[$];
    repeat (10) @(negedge clk);
    rst = 0;

    // Directed packets
    set_limit(16'd1510);
    clean_shape(); p_mss = 1460; send_packet();
    clean_shape(); p_mss = 16'hFFFF; p_pay = 1; send_packet();
    clean_shape(); p_mss = 0; send_packet();
    clean_shape(); p_opt = 1; send_packet();
    clean_shape(); p_opt = 3; send_packet();
    clean_shape(); p_opt = 4; send_packet();
    clean_shape(); p_opt = 5; send_packet();
    clean_shape(); p_opt = 2; send_packet();
    clean_shape(); p_syn = 0; send_packet();
    clean_shape(); p_frag = 'h0001; send_packet();
    clean_shape(); p_frag = 'h8000; send_packet();
    clean_shape(); p_ver = 6; send_packet();
    clean_shape(); p_proto = 17; send_packet();
    clean_shape(); p_cut = 12; send_packet();
    clean_shape(); p_tl_delta = 8; send_packet();
    clean_shape(); p_tl_delta = -12; send_packet();
    clean_shape(); p_doff = 15; p_tl_delta = -30; send_packet();
    clean_shape(); p_ihl = 3; p_frag = 0; send_packet();
    clean_shape(); p_ihl = 15; p_doff = 15; p_mss = 9000; send_packet();
    clean_shape(); p_opt = 6; p_doff = 15; p_tail = 5; send_packet();
    set_limit(16'd0);
    clean_shape(); send_packet();
    set_limit(16'd1);
    clean_shape(); send_packet();
    set_limit(16'd65535);
    clean_shape(); send_packet();

    // Random packets across several register settings
    limits = '{16'd50, 16'd49, 16'd1450, 16'd0, 16'd65535, 16'd1500, 16'd536, 16'd1};
    for (int ph = 0; bytes_sent < 1350; ph++) begin
      set_limit((ph % 3 == 2) ? 16'($urandom_range(0, 65535)) : limits[ph % limits.size()]);
      repeat (6) begin
        if (bytes_sent > 1200) quiet = 1;
        random_shape();
        send_packet();
      end
    end
    s_tvalid = 0;
    s_tlast = 0;

    while (patches_due != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    $display("Sent %0d packets (%0d bytes) over several path size settings,", packets_sent,
             bytes_sent);
    $display("%0d patches checked, %0d of them clamped.", patches_seen, clamps_seen);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("FAIL");
    $finish;
  end

endmodule
